>>> hdl/knh_pkg.sv
// ----------------------------------------------------------------------------
// knh_pkg: shared types and constants of the knn height average block
// Field widths, payload structs, register indexes and the per-cell
// entry and control types.
// ----------------------------------------------------------------------------
package knh_pkg;

	localparam int COORD_BITS             = 24;
	localparam int SQ_BITS                = 2 * COORD_BITS;
	localparam int DIST_BITS              = SQ_BITS + 1;
	localparam int K_BITS                 = 4;
	localparam int USED_BITS              = 4;
	localparam int CFG_INDEX_BITS         = 2;
	localparam int DEFAULT_MAX_NEIGHBOURS = 8;

	localparam logic [K_BITS-1:0] DEFAULT_K = K_BITS'(3);

	localparam logic [CFG_INDEX_BITS-1:0] REG_QUERY_X         = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_QUERY_Y         = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_NEIGHBOUR_COUNT = 2'd2;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic signed [COORD_BITS-1:0] point_height;
		logic                         last_point;
	} knh_point_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] mean_height;
		logic        [USED_BITS-1:0]  used_count;
	} knh_result_t;

	typedef struct packed {
		logic                         valid;
		logic        [DIST_BITS-1:0]  distance;
		logic signed [COORD_BITS-1:0] height;
	} knh_entry_t;

	typedef struct packed {
		logic clear;
		logic insert;
		logic shift;
	} knh_cell_ctrl_t;

endpackage

>>> hdl/knh_cell.sv
// ----------------------------------------------------------------------------
// knh_cell: one slot of the sorted neighbor chain
// Holds one kept point. On insert it keeps its point, takes the new point
// or takes its lower neighbor's point; on shift it takes its upper
// neighbor's point so the chain drains toward slot zero.
// ----------------------------------------------------------------------------
module knh_cell
	import knh_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  knh_cell_ctrl_t ctrl,
	input  knh_entry_t     new_entry,
	input  knh_entry_t     prev_entry,
	input  logic           prev_keep,
	input  knh_entry_t     next_entry,
	output knh_entry_t     entry,
	output logic           keep
);

	logic                         valid_q;
	logic        [DIST_BITS-1:0]  dist_q;
	logic signed [COORD_BITS-1:0] height_q;

	// equal distance keeps the older point in front
	assign keep  = valid_q && (dist_q <= new_entry.distance);
	assign entry = '{valid: valid_q, distance: dist_q, height: height_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_entry.valid;
		end else if (ctrl.insert && !keep) begin
			valid_q <= prev_keep ? 1'b1 : prev_entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			dist_q   <= next_entry.distance;
			height_q <= next_entry.height;
		end else if (ctrl.insert && !keep) begin
			if (prev_keep) begin
				dist_q   <= new_entry.distance;
				height_q <= new_entry.height;
			end else begin
				dist_q   <= prev_entry.distance;
				height_q <= prev_entry.height;
			end
		end
	end

endmodule

>>> hdl/knh_div.sv
// ----------------------------------------------------------------------------
// knh_div: signed sum by small count divider
// Restoring divider, one quotient bit per cycle, quotient truncated
// toward zero.
// ----------------------------------------------------------------------------
module knh_div
	import knh_pkg::*;
#(
	parameter int SUM_BITS = COORD_BITS + 4,
	parameter int CNT_W    = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [SUM_BITS-1:0] dividend,
	input  logic        [CNT_W-1:0]    divisor,
	output logic                       done,
	output logic signed [SUM_BITS-1:0] quotient
);

	localparam int STEP_W = $clog2(SUM_BITS + 1);

	logic                       busy_q;
	logic                       done_q;
	logic [STEP_W-1:0]          step_q;
	logic                       neg_q;
	logic [CNT_W-1:0]           den_q;
	logic [CNT_W-1:0]           rem_q;
	logic [SUM_BITS-1:0]        quo_q;
	logic signed [SUM_BITS-1:0] res_q;

	logic [CNT_W:0] trial;
	logic           ge;

	assign trial = {rem_q, quo_q[SUM_BITS-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(SUM_BITS);
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q - STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_BITS-1];
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend[SUM_BITS-1] ? (~dividend + SUM_BITS'(1)) : dividend;
		end else if (busy_q) begin
			if (step_q == '0) begin
				res_q <= neg_q ? (~quo_q + SUM_BITS'(1)) : quo_q;
			end else begin
				rem_q <= ge ? CNT_W'(trial - {1'b0, den_q}) : trial[CNT_W-1:0];
				quo_q <= {quo_q[SUM_BITS-2:0], ge};
			end
		end
	end

	assign done     = done_q;
	assign quotient = res_q;

endmodule

>>> hdl/knn_height_average.sv
// ----------------------------------------------------------------------------
// knn_height_average: k nearest neighbor height average
// Streams points against a query position, keeps the nearest ones in a
// sorted chain of cells and reports the mean height after the last point.
// ----------------------------------------------------------------------------
// Points are taken one per cycle while in_stall is low. Each passes a
// three-stage distance pipeline (absolute differences, squares, sum)
// and is then inserted into a sorted chain of MAX_NEIGHBOURS cells,
// earlier points in front on equal distance. Once a request with
// last_point is taken, the input stalls while the pipeline drains,
// the chain shifts its first k cells out one per cycle into an adder, and
// a one-bit-per-cycle divider forms the mean. The chain is cleared as its
// k-th cell is read, so it is empty when the next query's points come. A
// result waits in an output register without holding up the next query's
// points; neighbour_count of 0 counts as 1, above MAX_NEIGHBOURS as
// MAX_NEIGHBOURS. MAX_NEIGHBOURS ranges from 1 to 32.
// ----------------------------------------------------------------------------
module knn_height_average
	import knh_pkg::*;
#(
	parameter int MAX_NEIGHBOURS = DEFAULT_MAX_NEIGHBOURS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  knh_point_t                in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output knh_result_t               out_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]     cfg_data
);

	localparam int CNT_W    = $clog2(MAX_NEIGHBOURS + 1);
	localparam int SUM_BITS = COORD_BITS + CNT_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SUM  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;

	logic signed [COORD_BITS-1:0] query_x_q;
	logic signed [COORD_BITS-1:0] query_y_q;
	logic        [K_BITS-1:0]     nbr_count_q;

	logic [1:0] state_q;

	// distance pipeline
	logic                         v_s1, v_s2, v_s3;
	logic                         last_s1, last_s2, last_s3;
	logic        [COORD_BITS-1:0] dx_s1, dy_s1;
	logic signed [COORD_BITS-1:0] h_s1, h_s2, h_s3;
	logic        [SQ_BITS-1:0]    sqx_s2, sqy_s2;
	logic        [DIST_BITS-1:0]  dist_s3;

	logic signed [COORD_BITS:0] diff_x, diff_y;
	logic        [COORD_BITS:0] mag_x, mag_y;
	logic                       in_accept;
	logic                       last_pending;

	// averaging
	logic [CNT_W-1:0]           k_q;
	logic [CNT_W-1:0]           sum_cnt_q;
	logic signed [SUM_BITS-1:0] acc_q;
	logic [CNT_W-1:0]           used_q;
	logic signed [SUM_BITS-1:0] acc_next;
	logic [CNT_W-1:0]           used_next;
	logic [CNT_W-1:0]           k_eff;
	logic                       sum_last;
	logic                       div_start;
	logic                       div_done;
	logic signed [SUM_BITS-1:0] div_quot;

	logic        out_free;
	knh_result_t out_q;
	logic        out_valid_q;

	// chain
	knh_cell_ctrl_t            cell_ctrl;
	knh_entry_t                new_entry;
	knh_entry_t                ent [MAX_NEIGHBOURS];
	logic [MAX_NEIGHBOURS-1:0] keep;
	logic [MAX_NEIGHBOURS-1:0] vld;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_x_q   <= '0;
			query_y_q   <= '0;
			nbr_count_q <= DEFAULT_K;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_QUERY_X:         query_x_q   <= cfg_data;
				REG_QUERY_Y:         query_y_q   <= cfg_data;
				REG_NEIGHBOUR_COUNT: nbr_count_q <= cfg_data[K_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign last_pending = (v_s1 && last_s1) || (v_s2 && last_s2) || (v_s3 && last_s3);
	assign in_stall     = (state_q != ST_IDLE) || last_pending;
	assign in_accept    = in_valid && !in_stall;

	assign diff_x = {in_data.point_x[COORD_BITS-1], in_data.point_x}
	              - {query_x_q[COORD_BITS-1], query_x_q};
	assign diff_y = {in_data.point_y[COORD_BITS-1], in_data.point_y}
	              - {query_y_q[COORD_BITS-1], query_y_q};
	assign mag_x  = diff_x[COORD_BITS] ? (~diff_x + (COORD_BITS+1)'(1)) : diff_x;
	assign mag_y  = diff_y[COORD_BITS] ? (~diff_y + (COORD_BITS+1)'(1)) : diff_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1   <= mag_x[COORD_BITS-1:0];
		dy_s1   <= mag_y[COORD_BITS-1:0];
		h_s1    <= in_data.point_height;
		last_s1 <= in_data.last_point;
		sqx_s2  <= dx_s1 * dx_s1;
		sqy_s2  <= dy_s1 * dy_s1;
		h_s2    <= h_s1;
		last_s2 <= last_s1;
		dist_s3 <= DIST_BITS'(sqx_s2) + DIST_BITS'(sqy_s2);
		h_s3    <= h_s2;
		last_s3 <= last_s2;
	end

	assign new_entry = '{valid: 1'b1, distance: dist_s3, height: h_s3};

	assign sum_last         = (state_q == ST_SUM) && (sum_cnt_q == k_q - CNT_W'(1));
	assign div_start        = sum_last;
	assign cell_ctrl.insert = v_s3;
	assign cell_ctrl.shift  = (state_q == ST_SUM);
	assign cell_ctrl.clear  = sum_last;

	for (genvar i = 0; i < MAX_NEIGHBOURS; i++) begin : g_cell
		knh_entry_t prev_e;
		knh_entry_t next_e;
		logic       prev_k;

		if (i == 0) begin : g_first
			assign prev_e = new_entry;
			assign prev_k = 1'b1;
		end else begin : g_inner
			assign prev_e = ent[i-1];
			assign prev_k = keep[i-1];
		end

		if (i == MAX_NEIGHBOURS - 1) begin : g_end
			assign next_e = '0;
		end else begin : g_mid
			assign next_e = ent[i+1];
		end

		knh_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl),
			.new_entry  (new_entry),
			.prev_entry (prev_e),
			.prev_keep  (prev_k),
			.next_entry (next_e),
			.entry      (ent[i]),
			.keep       (keep[i])
		);

		assign vld[i] = ent[i].valid;
	end

	always_comb begin
		if (nbr_count_q == '0) begin
			k_eff = CNT_W'(1);
		end else if (int'(nbr_count_q) > MAX_NEIGHBOURS) begin
			k_eff = CNT_W'(MAX_NEIGHBOURS);
		end else begin
			k_eff = CNT_W'(nbr_count_q);
		end
	end

	// slot zero is read while the chain shifts down
	assign acc_next  = acc_q + (ent[0].valid
	                 ? {{(SUM_BITS-COORD_BITS){ent[0].height[COORD_BITS-1]}}, ent[0].height}
	                 : SUM_BITS'(0));
	assign used_next = used_q + CNT_W'(ent[0].valid);

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sum_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (v_s3 && last_s3) begin
						state_q   <= ST_SUM;
						sum_cnt_q <= '0;
					end
				end
				ST_SUM: begin
					sum_cnt_q <= sum_cnt_q + CNT_W'(1);
					if (sum_last) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done && out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			k_q    <= k_eff;
			acc_q  <= '0;
			used_q <= '0;
		end else if (state_q == ST_SUM) begin
			acc_q  <= acc_next;
			used_q <= used_next;
		end
	end

	knh_div #(
		.SUM_BITS (SUM_BITS),
		.CNT_W    (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_next),
		.divisor  (used_next),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DIV) && div_done && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV) && div_done && out_free) begin
			out_q.mean_height <= div_quot[COORD_BITS-1:0];
			out_q.used_count  <= USED_BITS'(used_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && in_data.last_point) |=> in_stall)
		else $error("input not stalled after last point");

	a_sum_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |-> !(v_s1 || v_s2 || v_s3))
		else $error("distance pipeline busy while averaging");

	a_chain_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(vld & (vld + MAX_NEIGHBOURS'(1))) == '0)
		else $error("kept slots not contiguous from slot zero");

	a_first_slot_used: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (used_next != '0))
		else $error("divider started with zero count");

	a_result_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DIV && div_done))
		else $error("result raised without a finished division");

endmodule
